@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ sv/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared widths, request kinds and defaults of the ARP cache table.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam int TABLE_ENTRIES_DEF = 8;

   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;
   localparam int OPER_W = 16;
   localparam int KIND_W = 2;

   // req_tdata: ip_addr, mac_addr, arp_oper, dest_ip from bit 0 up
   localparam int REQ_DATA_W = IP_W + MAC_W + OPER_W + IP_W;
   // rsp_tdata: status, found_mac, send_reply, reply_dst_mac, reply_dest_ip
   localparam int RSP_USED_W = 1 + MAC_W + 1 + MAC_W + IP_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   typedef logic [KIND_W-1:0] req_kind_type;

   localparam req_kind_type REQ_LOOKUP = 2'd0;
   localparam req_kind_type REQ_ADD    = 2'd1;
   localparam req_kind_type REQ_PACKET = 2'd2;

   localparam logic [OPER_W-1:0] ARP_OPER_REQUEST = 16'd1;

endpackage

@@ sv/arp_cache_table_core.sv @@
// ----------------------------------------------------------------------------
// arp_cache_table_core
// Small ARP cache: lookup, add or update, and learning from received packets.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: req_tuser is the kind (lookup, add, packet),
//   req_tdata the addresses and opcode. rsp_* returns exactly one result per
//   request. csr_wr_en/csr_wr_data load the station's own IP; the user must
//   write it only while idle, the block does not enforce this. A request
//   that touches the table walks all TABLE_ENTRIES entries through the
//   single read port, one entry per cycle, with one comparator against the
//   key and one against zero tracking the first match and the first free
//   entry, then waits in the decide state for the output register. A request
//   that skips the table (packet with sender IP zero, unused kind) goes
//   straight to the decide state. req_tready is high only while idle. The
//   result waits in an output register; a new request may be accepted and
//   scanned while it waits, and its result is held back until rsp_tready
//   takes the previous one.
//   Reset clears own IP and marks every entry free at once; no sweep.
// ----------------------------------------------------------------------------
module arp_cache_table_core #(
   parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: ip_addr[31:0], mac_addr[79:32], arp_oper[95:80], dest_ip[127:96]
   input  logic [arpc_pkg::REQ_DATA_W-1:0] req_tdata,
   // request kind: req_type[1:0]
   input  logic [arpc_pkg::KIND_W-1:0]     req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // result: status[0], found_mac[48:1], send_reply[49], reply_dst_mac[97:50],
   // reply_dest_ip[129:98], zero fill above
   output logic [arpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic [arpc_pkg::IP_W-1:0]       csr_wr_data
);
   import arpc_pkg::*;
   `include "assert_macros.svh"

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // control
   state_type          state_ff, state_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [IP_W-1:0]    own_ip_ff, own_ip_in;
   logic [CNT_W-1:0]   issue_cnt_ff, issue_cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic               hit_ff, hit_in;
   logic               free_ff, free_in;
   // payload
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [MAC_W-1:0]   hit_mac_ff, hit_mac_in;
   req_kind_type       kind_ff, kind_in;
   logic [IP_W-1:0]    key_ip_ff, key_ip_in;
   logic [MAC_W-1:0]   key_mac_ff, key_mac_in;
   logic               learn_ff, learn_in;
   logic               reply_ff, reply_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // request fields
   logic [IP_W-1:0]    req_ip;
   logic [MAC_W-1:0]   req_mac;
   logic [OPER_W-1:0]  req_oper;
   logic [IP_W-1:0]    req_target;
   req_kind_type       req_kind;
   logic               req_fire;

   // table port
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [IP_W-1:0]    rd_ip;
   logic [MAC_W-1:0]   rd_mac;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;

   // comparators and result assembly
   logic               eq_key;
   logic               eq_zero;
   logic               slot_free;
   logic               res_status;
   logic [MAC_W-1:0]   res_found;

   assign req_ip     = req_tdata[IP_W-1:0];
   assign req_mac    = req_tdata[IP_W+MAC_W-1:IP_W];
   assign req_oper   = req_tdata[IP_W+MAC_W+OPER_W-1:IP_W+MAC_W];
   assign req_target = req_tdata[REQ_DATA_W-1:IP_W+MAC_W+OPER_W];
   assign req_kind   = req_tuser;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   // compare the entry read last cycle against the key and against free
   assign eq_key  = (rd_ip == key_ip_ff);
   assign eq_zero = (rd_ip == '0);

   // issue one entry read per cycle during the scan
   assign rd_en   = (state_ff == ST_SCAN) && (issue_cnt_ff != CNT_W'(TABLE_ENTRIES));
   assign rd_addr = issue_cnt_ff[IDX_W-1:0];

   // pick the write target and the status of the request
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = hit_idx_ff;
      res_status = 1'b0;
      res_found  = '0;
      unique case (kind_ff)
         REQ_LOOKUP: begin
            res_status = !hit_ff;
            res_found  = hit_ff ? hit_mac_ff : '0;
         end
         REQ_ADD, REQ_PACKET: begin
            priority if (!learn_ff) begin
               res_status = 1'b0;
            end else if (hit_ff) begin
               wr_en   = 1'b1;
            end else if (free_ff) begin
               wr_en   = 1'b1;
               wr_addr = free_idx_ff;
            end else begin
               res_status = 1'b1;
            end
         end
         default: begin
            res_status = 1'b0;
         end
      endcase
      wr_en = wr_en && (state_ff == ST_DECIDE) && slot_free;
   end

   // next state
   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      own_ip_in     = own_ip_ff;
      issue_cnt_in  = issue_cnt_ff;
      chk_vld_in    = rd_en;
      chk_idx_in    = rd_addr;
      hit_in        = hit_ff;
      free_in       = free_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      hit_mac_in    = hit_mac_ff;
      kind_in       = kind_ff;
      key_ip_in     = key_ip_ff;
      key_mac_in    = key_mac_ff;
      learn_in      = learn_ff;
      reply_in      = reply_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      // drop a result once taken
      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      if (csr_wr_en) begin
         own_ip_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in      = req_kind;
               key_ip_in    = req_ip;
               key_mac_in   = req_mac;
               learn_in     = (req_kind == REQ_ADD) ||
                              ((req_kind == REQ_PACKET) && (req_ip != '0));
               reply_in     = (req_kind == REQ_PACKET) &&
                              (req_oper == ARP_OPER_REQUEST) &&
                              (req_target == own_ip_ff);
               issue_cnt_in = '0;
               hit_in       = 1'b0;
               free_in      = 1'b0;
               if ((req_kind == REQ_LOOKUP) || (req_kind == REQ_ADD) ||
                   ((req_kind == REQ_PACKET) && (req_ip != '0))) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
            // keep the first match and the first free entry
            if (chk_vld_ff) begin
               if (eq_key && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_mac_in = rd_mac;
               end
               if (eq_zero && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (chk_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            // hold until the output register is free
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_DATA_W'({
                  reply_ff ? key_ip_ff  : {IP_W{1'b0}},
                  reply_ff ? key_mac_ff : {MAC_W{1'b0}},
                  reply_ff,
                  res_found,
                  res_status});
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         own_ip_ff     <= '0;
         issue_cnt_ff  <= '0;
         chk_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         own_ip_ff     <= own_ip_in;
         issue_cnt_ff  <= issue_cnt_in;
         chk_vld_ff    <= chk_vld_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
      end
      chk_idx_ff   <= chk_idx_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      hit_mac_ff   <= hit_mac_in;
      kind_ff      <= kind_in;
      key_ip_ff    <= key_ip_in;
      key_mac_ff   <= key_mac_in;
      learn_ff     <= learn_in;
      reply_ff     <= reply_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   arpc_table #(
      .ENTRIES (TABLE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_ip   (rd_ip),
      .rd_mac  (rd_mac),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_ip   (key_ip_ff),
      .wr_mac  (key_mac_ff)
   );

   // an accepted request keeps the block busy after it is accepted
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready, "ready right after accept")
   // only a learning request writes the table
   `ASSERT_IMPLIES(a_write_only_learn, clock, reset, wr_en, learn_ff && (kind_ff != REQ_LOOKUP), "table write without learning")
   // a reply and a lookup hit never share one result
   `ASSERT_IMPLIES(a_reply_no_found, clock, reset, rsp_tvalid && rsp_tdata[1+MAC_W], rsp_tdata[MAC_W:1] == '0, "reply with found MAC")

endmodule

@@ sv/arpc_table.sv @@
// ----------------------------------------------------------------------------
// arpc_table
// Entry store of IP and MAC pairs: one write port, one registered read port.
// Per-entry valid bits make every entry read as zero after reset.
// ----------------------------------------------------------------------------
module arpc_table #(
   parameter int ENTRIES = 8,
   parameter int IDX_W   = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic [arpc_pkg::IP_W-1:0]  rd_ip,
   output logic [arpc_pkg::MAC_W-1:0] rd_mac,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [arpc_pkg::IP_W-1:0]  wr_ip,
   input  logic [arpc_pkg::MAC_W-1:0] wr_mac
);
   import arpc_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   logic [IP_W-1:0]    ip_mem_ff  [ENTRIES];
   logic [MAC_W-1:0]   mac_mem_ff [ENTRIES];
   logic [IP_W-1:0]    rd_ip_ff;
   logic [MAC_W-1:0]   rd_mac_ff;

   // mark entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ip_mem_ff[wr_addr]  <= wr_ip;
         mac_mem_ff[wr_addr] <= wr_mac;
      end
   end

   // read the entry; an entry never written reads as free
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ip_ff  <= valid_ff[rd_addr] ? ip_mem_ff[rd_addr]  : '0;
         rd_mac_ff <= valid_ff[rd_addr] ? mac_mem_ff[rd_addr] : '0;
      end
   end

   assign rd_ip  = rd_ip_ff;
   assign rd_mac = rd_mac_ff;

endmodule
